>>> hdl/bc_pkg.sv
// Shared widths, constants and the division cell record for the barycentric weight block.
package bc_pkg;

	localparam int COORD_W  = 24;
	localparam int FRAC_W   = 28;
	localparam int WEIGHT_W = 32;
	localparam int THRESH_W = 63;

	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD1_W = 2 * DIFF_W;
	localparam int DOT_W   = 2 * COORD_W + 4;
	localparam int HALF_W  = DOT_W / 2;
	localparam int PROD_W  = 2 * DOT_W;
	localparam int NUM_W   = PROD_W + 1;
	localparam int DEN_W   = PROD_W;
	localparam int MAG_W   = PROD_W;
	localparam int SH_W    = WEIGHT_W - FRAC_W;
	localparam int LANES   = 3;
	localparam int DIV_STEPS = WEIGHT_W;

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(64'd184467441);

	localparam logic [WEIGHT_W-1:0] W_033 =
		WEIGHT_W'(((64'd33 << FRAC_W) + 64'd50) / 64'd100);
	localparam logic [WEIGHT_W-1:0] W_034 =
		WEIGHT_W'(((64'd34 << FRAC_W) + 64'd50) / 64'd100);
	localparam logic [WEIGHT_W-1:0] W_POS_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
	localparam logic [WEIGHT_W-1:0] W_NEG_MAX = {1'b1, {(WEIGHT_W-1){1'b0}}};

	typedef struct packed {
		logic                              vld;
		logic                              degen;
		logic [DEN_W-1:0]                  den;
		logic [LANES-1:0]                  neg;
		logic [LANES-1:0]                  ovf;
		logic [LANES-1:0][DEN_W-1:0]       rem;
		logic [LANES-1:0][WEIGHT_W-1:0]    w;
	} div_stage_t;

endpackage

>>> hdl/bc_wide_mul.sv
// Three-stage signed multiplier built from four half-width partial products.
module bc_wide_mul (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [bc_pkg::DOT_W-1:0]     a,
	input  logic signed [bc_pkg::DOT_W-1:0]     b,
	output logic signed [bc_pkg::PROD_W-1:0]    p
);
	localparam int H = bc_pkg::HALF_W;
	localparam int D = bc_pkg::DOT_W;

	logic signed [H-1:0]   ah, bh;
	logic        [H-1:0]   al, bl;
	logic signed [D-1:0]   hh_s1;
	logic        [D-1:0]   ll_s1;
	logic signed [D:0]     hl_s1, lh_s1;
	logic        [bc_pkg::PROD_W-1:0] base_s2;
	logic signed [D+1:0]   cross_s2;
	logic signed [bc_pkg::PROD_W-1:0] p_s3;

	assign ah = a[D-1:H];
	assign bh = b[D-1:H];
	assign al = a[H-1:0];
	assign bl = b[H-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			hh_s1    <= ah * bh;
			ll_s1    <= al * bl;
			hl_s1    <= ah * $signed({1'b0, bl});
			lh_s1    <= $signed({1'b0, al}) * bh;
			base_s2  <= {hh_s1, ll_s1};
			cross_s2 <= (D+2)'(hl_s1) + (D+2)'(lh_s1);
			p_s3     <= $signed(base_s2) + (bc_pkg::PROD_W'(cross_s2) <<< H);
		end
	end

	assign p = p_s3;
endmodule

>>> hdl/bc_div_cell.sv
// One restoring division step for all three weight lanes, passed on to the next cell.
module bc_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bc_pkg::div_stage_t  d,
	output bc_pkg::div_stage_t  q
);
	localparam int DW = bc_pkg::DEN_W;

	bc_pkg::div_stage_t nxt;
	logic [DW:0]   rem2;
	logic [DW+1:0] diff;
	logic          ge;

	always_comb begin
		nxt = d;
		rem2 = '0;
		diff = '0;
		ge = 1'b0;
		for (int l = 0; l < bc_pkg::LANES; l++) begin
			rem2 = {d.rem[l], d.w[l][bc_pkg::WEIGHT_W-1]};
			diff = {1'b0, rem2} - {2'b00, d.den};
			ge = !diff[DW+1];
			nxt.rem[l] = ge ? diff[DW-1:0] : rem2[DW-1:0];
			nxt.w[l] = {d.w[l][bc_pkg::WEIGHT_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nxt;
		end
	end
endmodule

>>> hdl/barycentric_coordinates_top.sv
// Top level of the pipelined barycentric weight block.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_ready   a_*, b_*, c_*, pt_* (signed Q8.16)
//   result    out        out_valid / out_ready weight_a/b/c (Q3.28), degenerate, saturated
//   config    in         cfg_we                cfg_wdata (degenerate threshold)
//
// One item enters per cycle while the pipeline advances. Each item passes nine
// front stages (differences, small products, dot sums, three-stage wide multipliers,
// numerators, magnitudes), one setup stage, a chain of 32 division cells and the
// output register. The division chain, one quotient bit per cell, is the longest part.
// The whole pipeline advances whenever the output register is empty or being taken,
// so in_ready follows out_ready. Reset clears the valid bits and loads the threshold.
module barycentric_coordinates_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [bc_pkg::COORD_W-1:0]    a_x,
	input  logic signed [bc_pkg::COORD_W-1:0]    a_y,
	input  logic signed [bc_pkg::COORD_W-1:0]    a_z,
	input  logic signed [bc_pkg::COORD_W-1:0]    b_x,
	input  logic signed [bc_pkg::COORD_W-1:0]    b_y,
	input  logic signed [bc_pkg::COORD_W-1:0]    b_z,
	input  logic signed [bc_pkg::COORD_W-1:0]    c_x,
	input  logic signed [bc_pkg::COORD_W-1:0]    c_y,
	input  logic signed [bc_pkg::COORD_W-1:0]    c_z,
	input  logic signed [bc_pkg::COORD_W-1:0]    pt_x,
	input  logic signed [bc_pkg::COORD_W-1:0]    pt_y,
	input  logic signed [bc_pkg::COORD_W-1:0]    pt_z,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [bc_pkg::WEIGHT_W-1:0]   weight_a,
	output logic signed [bc_pkg::WEIGHT_W-1:0]   weight_b,
	output logic signed [bc_pkg::WEIGHT_W-1:0]   weight_c,
	output logic                                 degenerate,
	output logic                                 saturated,
	input  logic                                 cfg_we,
	input  logic [bc_pkg::THRESH_W-1:0]          cfg_wdata
);
	localparam int DIFF_W  = bc_pkg::DIFF_W;
	localparam int PROD1_W = bc_pkg::PROD1_W;
	localparam int DOT_W   = bc_pkg::DOT_W;
	localparam int PROD_W  = bc_pkg::PROD_W;
	localparam int NUM_W   = bc_pkg::NUM_W;
	localparam int DEN_W   = bc_pkg::DEN_W;
	localparam int MAG_W   = bc_pkg::MAG_W;
	localparam int WW      = bc_pkg::WEIGHT_W;
	localparam int LANES   = bc_pkg::LANES;

	// The whole pipeline moves together; it stops only when a finished item waits.
	logic adv;
	logic out_vld_q;
	assign adv = !out_vld_q || out_ready;
	assign in_ready = adv;

	logic [bc_pkg::THRESH_W-1:0] thr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= bc_pkg::THRESH_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Valid bits of the front stages, first stage through the magnitude stage.
	logic [8:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[7:0], in_valid};
		end
	end

	// Stage 1: edge vectors and the vector to the query point.
	logic signed [DIFF_W-1:0] e1_s1 [LANES];
	logic signed [DIFF_W-1:0] e2_s1 [LANES];
	logic signed [DIFF_W-1:0] qv_s1 [LANES];
	logic signed [bc_pkg::COORD_W-1:0] av [LANES];
	logic signed [bc_pkg::COORD_W-1:0] bv [LANES];
	logic signed [bc_pkg::COORD_W-1:0] cv [LANES];
	logic signed [bc_pkg::COORD_W-1:0] pv [LANES];

	assign av = '{a_x, a_y, a_z};
	assign bv = '{b_x, b_y, b_z};
	assign cv = '{c_x, c_y, c_z};
	assign pv = '{pt_x, pt_y, pt_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				e1_s1[i] <= DIFF_W'(bv[i]) - DIFF_W'(av[i]);
				e2_s1[i] <= DIFF_W'(cv[i]) - DIFF_W'(av[i]);
				qv_s1[i] <= DIFF_W'(pv[i]) - DIFF_W'(av[i]);
			end
		end
	end

	// Stage 2: the fifteen coordinate products.
	logic signed [PROD1_W-1:0] p11_s2 [LANES];
	logic signed [PROD1_W-1:0] p12_s2 [LANES];
	logic signed [PROD1_W-1:0] p22_s2 [LANES];
	logic signed [PROD1_W-1:0] pq1_s2 [LANES];
	logic signed [PROD1_W-1:0] pq2_s2 [LANES];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				p11_s2[i] <= e1_s1[i] * e1_s1[i];
				p12_s2[i] <= e1_s1[i] * e2_s1[i];
				p22_s2[i] <= e2_s1[i] * e2_s1[i];
				pq1_s2[i] <= qv_s1[i] * e1_s1[i];
				pq2_s2[i] <= qv_s1[i] * e2_s1[i];
			end
		end
	end

	// Stage 3: the five dot products.
	logic signed [DOT_W-1:0] d00_s3, d01_s3, d11_s3, d20_s3, d21_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			d00_s3 <= DOT_W'(p11_s2[0]) + DOT_W'(p11_s2[1]) + DOT_W'(p11_s2[2]);
			d01_s3 <= DOT_W'(p12_s2[0]) + DOT_W'(p12_s2[1]) + DOT_W'(p12_s2[2]);
			d11_s3 <= DOT_W'(p22_s2[0]) + DOT_W'(p22_s2[1]) + DOT_W'(p22_s2[2]);
			d20_s3 <= DOT_W'(pq1_s2[0]) + DOT_W'(pq1_s2[1]) + DOT_W'(pq1_s2[2]);
			d21_s3 <= DOT_W'(pq2_s2[0]) + DOT_W'(pq2_s2[1]) + DOT_W'(pq2_s2[2]);
		end
	end

	// Stages 4 to 6: the six wide products.
	logic signed [PROD_W-1:0] m0011, m0101, m1120, m0121, m0021, m0120;

	bc_wide_mul u_mul_0011 (.clk(clk), .en(adv), .a(d00_s3), .b(d11_s3), .p(m0011));
	bc_wide_mul u_mul_0101 (.clk(clk), .en(adv), .a(d01_s3), .b(d01_s3), .p(m0101));
	bc_wide_mul u_mul_1120 (.clk(clk), .en(adv), .a(d11_s3), .b(d20_s3), .p(m1120));
	bc_wide_mul u_mul_0121 (.clk(clk), .en(adv), .a(d01_s3), .b(d21_s3), .p(m0121));
	bc_wide_mul u_mul_0021 (.clk(clk), .en(adv), .a(d00_s3), .b(d21_s3), .p(m0021));
	bc_wide_mul u_mul_0120 (.clk(clk), .en(adv), .a(d01_s3), .b(d20_s3), .p(m0120));

	// Stage 7: denominator and the two direct numerators.
	logic [DEN_W-1:0]        den_s7;
	logic signed [NUM_W-1:0] n1_s7, n2_s7;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s7 <= DEN_W'(m0011 - m0101);
			n1_s7  <= NUM_W'(m1120) - NUM_W'(m0121);
			n2_s7  <= NUM_W'(m0021) - NUM_W'(m0120);
		end
	end

	// Stage 8: first numerator and the degenerate test.
	logic [DEN_W-1:0]        den_s8;
	logic signed [NUM_W-1:0] n_s8 [LANES];
	logic                    degen_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s8   <= den_s7;
			n_s8[0]  <= NUM_W'(den_s7) - n1_s7 - n2_s7;
			n_s8[1]  <= n1_s7;
			n_s8[2]  <= n2_s7;
			degen_s8 <= den_s7 <= DEN_W'(thr_q);
		end
	end

	// Stage 9: sign and magnitude of each numerator.
	logic [DEN_W-1:0]  den_s9;
	logic [MAG_W-1:0]  mag_s9 [LANES];
	logic [LANES-1:0]  neg_s9;
	logic              degen_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s9   <= den_s8;
			degen_s9 <= degen_s8;
			for (int i = 0; i < LANES; i++) begin
				neg_s9[i] <= n_s8[i][NUM_W-1];
				mag_s9[i] <= MAG_W'(n_s8[i][NUM_W-1] ? -n_s8[i] : n_s8[i]);
			end
		end
	end

	// Setup stage: the top part of the scaled dividend becomes the first partial
	// remainder. When it already reaches the denominator the quotient needs more
	// than 32 bits, so that lane will saturate.
	bc_pkg::div_stage_t chain [bc_pkg::DIV_STEPS+1];
	bc_pkg::div_stage_t setup_d;
	bc_pkg::div_stage_t setup_q;

	always_comb begin
		setup_d.vld   = vld_q[8];
		setup_d.degen = degen_s9;
		setup_d.den   = den_s9;
		setup_d.neg   = neg_s9;
		for (int i = 0; i < LANES; i++) begin
			setup_d.rem[i] = DEN_W'(mag_s9[i] >> bc_pkg::SH_W);
			setup_d.w[i]   = {mag_s9[i][bc_pkg::SH_W-1:0], {bc_pkg::FRAC_W{1'b0}}};
			setup_d.ovf[i] = DEN_W'(mag_s9[i] >> bc_pkg::SH_W) >= den_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q <= '0;
		end else if (adv) begin
			setup_q <= setup_d;
		end
	end

	assign chain[0] = setup_q;

	// Each cell settles one quotient bit of all three weights.
	for (genvar g = 0; g < bc_pkg::DIV_STEPS; g++) begin : g_div
		bc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.d      (chain[g]),
			.q      (chain[g+1])
		);
	end

	// Saturation, sign and the fixed weights of a degenerate triangle.
	bc_pkg::div_stage_t last;
	logic [WW-1:0]      wt [LANES];
	logic [LANES-1:0]   sat_l;
	logic [WW-1:0]      qv;

	assign last = chain[bc_pkg::DIV_STEPS];

	always_comb begin
		qv = '0;
		for (int i = 0; i < LANES; i++) begin
			qv = last.w[i];
			if (last.neg[i]) begin
				sat_l[i] = last.ovf[i] || (qv[WW-1] && (|qv[WW-2:0]));
				wt[i] = sat_l[i] ? bc_pkg::W_NEG_MAX : -qv;
			end else begin
				sat_l[i] = last.ovf[i] || qv[WW-1];
				wt[i] = sat_l[i] ? bc_pkg::W_POS_MAX : qv;
			end
		end
	end

	logic [WW-1:0] wa_q, wb_q, wc_q;
	logic          degen_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= last.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (last.degen) begin
				wa_q    <= bc_pkg::W_033;
				wb_q    <= bc_pkg::W_033;
				wc_q    <= bc_pkg::W_034;
				degen_q <= 1'b1;
				sat_q   <= 1'b0;
			end else begin
				wa_q    <= wt[0];
				wb_q    <= wt[1];
				wc_q    <= wt[2];
				degen_q <= 1'b0;
				sat_q   <= |sat_l;
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign weight_a   = wa_q;
	assign weight_b   = wb_q;
	assign weight_c   = wc_q;
	assign degenerate = degen_q;
	assign saturated  = sat_q;
endmodule

>>> tb/barycentric_coordinates_top_tb.sv
// Self-checking testbench for the pipelined barycentric weight block.
`timescale 1ns / 1ps

module barycentric_coordinates_top_tb;

	// Generous cycle limit; a correct run needs a small fraction of it.
	localparam int CYCLE_LIMIT = 500000;
	// Extra wait after the last result; longer than the pipeline from input to result.
	localparam int DRAIN_CYCLES = 60;
	localparam int IDLE_PCT = 18;

	typedef logic signed [bc_pkg::COORD_W-1:0] coord_t;

	// One query item: three triangle vertices and the point, all signed Q8.16.
	typedef struct packed {
		coord_t ax, ay, az;
		coord_t bx, by, bz;
		coord_t cx, cy, cz;
		coord_t px, py, pz;
	} tri_query_t;

	// One weight item as the block returns it.
	typedef struct packed {
		logic [bc_pkg::WEIGHT_W-1:0] wa;
		logic [bc_pkg::WEIGHT_W-1:0] wb;
		logic [bc_pkg::WEIGHT_W-1:0] wc;
		logic                        degen;
		logic                        sat;
	} weights_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	tri_query_t query;
	logic signed [bc_pkg::WEIGHT_W-1:0] weight_a, weight_b, weight_c;
	logic degenerate, saturated;
	logic cfg_we;
	logic [bc_pkg::THRESH_W-1:0] cfg_wdata;

	// The predictor's own copy of the threshold register.
	logic [bc_pkg::THRESH_W-1:0] degen_thresh;
	weights_t expected_weights[$];
	int unsigned mismatches;
	int unsigned cycle_count;
	// While set, neither side idles at random.
	bit steady;
	// Cycles left in a long receiver hold-off.
	int hold_left;

	barycentric_coordinates_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.a_x(query.ax), .a_y(query.ay), .a_z(query.az),
		.b_x(query.bx), .b_y(query.by), .b_z(query.bz),
		.c_x(query.cx), .c_y(query.cy), .c_z(query.cz),
		.pt_x(query.px), .pt_y(query.py), .pt_z(query.pz),
		.out_valid(out_valid), .out_ready(out_ready),
		.weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
		.degenerate(degenerate), .saturated(saturated),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is ended here if the block hangs.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// A weight is n * 2^FRAC_W / den, truncated toward zero, then clipped to 32 bits.
	// The top bit of the return value reports the clipping.
	function automatic logic [bc_pkg::WEIGHT_W:0] scale_weight(
			input logic signed [255:0] n, input logic [255:0] den);
		logic [255:0] mag;
		logic [255:0] quot;
		mag = n[255] ? 256'(-n) : 256'(n);
		quot = (mag << bc_pkg::FRAC_W) / den;
		if (!n[255]) begin
			if (quot > 256'h7FFF_FFFF)
				return {1'b1, bc_pkg::W_POS_MAX};
			return {1'b0, quot[bc_pkg::WEIGHT_W-1:0]};
		end
		if (quot > 256'h8000_0000)
			return {1'b1, bc_pkg::W_NEG_MAX};
		return {1'b0, bc_pkg::WEIGHT_W'(-quot[bc_pkg::WEIGHT_W-1:0])};
	endfunction

	// Exact integer predictor: every intermediate is held at 256 bits, so nothing wraps.
	function automatic weights_t predict_weights(input tri_query_t t);
		logic signed [255:0] e1x, e1y, e1z, e2x, e2y, e2z, qx, qy, qz;
		logic signed [255:0] d00, d01, d11, d20, d21, den, n0, n1, n2;
		logic [bc_pkg::WEIGHT_W:0] r0, r1, r2;
		weights_t w;
		e1x = 256'(t.bx) - 256'(t.ax);
		e1y = 256'(t.by) - 256'(t.ay);
		e1z = 256'(t.bz) - 256'(t.az);
		e2x = 256'(t.cx) - 256'(t.ax);
		e2y = 256'(t.cy) - 256'(t.ay);
		e2z = 256'(t.cz) - 256'(t.az);
		qx = 256'(t.px) - 256'(t.ax);
		qy = 256'(t.py) - 256'(t.ay);
		qz = 256'(t.pz) - 256'(t.az);
		d00 = e1x * e1x + e1y * e1y + e1z * e1z;
		d01 = e1x * e2x + e1y * e2y + e1z * e2z;
		d11 = e2x * e2x + e2y * e2y + e2z * e2z;
		d20 = qx * e1x + qy * e1y + qz * e1z;
		d21 = qx * e2x + qy * e2y + qz * e2z;
		den = d00 * d11 - d01 * d01;
		// The denominator is never negative, so an unsigned compare is safe.
		if ($unsigned(den) <= {193'b0, degen_thresh}) begin
			w.wa = bc_pkg::W_033;
			w.wb = bc_pkg::W_033;
			w.wc = bc_pkg::W_034;
			w.degen = 1'b1;
			w.sat = 1'b0;
			return w;
		end
		n1 = d11 * d20 - d01 * d21;
		n2 = d00 * d21 - d01 * d20;
		n0 = den - n1 - n2;
		r0 = scale_weight(n0, den);
		r1 = scale_weight(n1, den);
		r2 = scale_weight(n2, den);
		w.wa = r0[bc_pkg::WEIGHT_W-1:0];
		w.wb = r1[bc_pkg::WEIGHT_W-1:0];
		w.wc = r2[bc_pkg::WEIGHT_W-1:0];
		w.degen = 1'b0;
		w.sat = r0[bc_pkg::WEIGHT_W] | r1[bc_pkg::WEIGHT_W] | r2[bc_pkg::WEIGHT_W];
		return w;
	endfunction

	// Sends one item. Gaps are taken before valid rises; once high it holds until
	// accepted. The caller's next item follows at the next falling edge, so in_valid
	// gets one assignment per step.
	task automatic send_query(input tri_query_t t);
		@(negedge clk);
		while (take_break()) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		query <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_weights.push_back(predict_weights(t));
	endtask

	// Lowers valid, then waits for every outstanding result and the pipeline latency.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_weights.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Threshold writes happen only with the pipeline empty.
	task automatic write_threshold(input logic [bc_pkg::THRESH_W-1:0] value);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		degen_thresh = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic tri_query_t make_query(input coord_t ax, ay, az, bx, by, bz,
			cx, cy, cz, px, py, pz);
		tri_query_t t;
		t = {ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz};
		return t;
	endfunction

	// A random coordinate whose size is set by the shift: large shifts give small values.
	function automatic coord_t rand_coord(input int shift);
		coord_t r;
		r = coord_t'($urandom);
		return r >>> shift;
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		if (v < -64'sd8388608)
			return 24'sh800000;
		return coord_t'(v);
	endfunction

	// A well-formed triangle with the point at A + u*e1 + v*e2, u and v in 1/256 steps.
	// Most points land inside; some are pushed outside or far away.
	function automatic tri_query_t random_triangle();
		int shift;
		longint u, v;
		coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
		shift = $urandom_range(1, 21);
		ax = rand_coord(shift + 1);
		ay = rand_coord(shift + 1);
		az = rand_coord(shift + 1);
		bx = clamp_coord(longint'(ax) + rand_coord(shift + 1));
		by = clamp_coord(longint'(ay) + rand_coord(shift + 1));
		bz = clamp_coord(longint'(az) + rand_coord(shift + 1));
		cx = clamp_coord(longint'(ax) + rand_coord(shift + 1));
		cy = clamp_coord(longint'(ay) + rand_coord(shift + 1));
		cz = clamp_coord(longint'(az) + rand_coord(shift + 1));
		case ($urandom_range(9))
			0: begin
				u = longint'($urandom_range(2048)) - 1024;
				v = longint'($urandom_range(2048)) - 1024;
			end
			1: begin
				// Collinear vertices: C sits on the line through A and B.
				cx = clamp_coord(2 * longint'(bx) - ax);
				cy = clamp_coord(2 * longint'(by) - ay);
				cz = clamp_coord(2 * longint'(bz) - az);
				u = $urandom_range(256);
				v = $urandom_range(256);
			end
			default: begin
				u = $urandom_range(256);
				v = $urandom_range(256 - u);
			end
		endcase
		return make_query(ax, ay, az, bx, by, bz, cx, cy, cz,
			clamp_coord(ax + (u * (bx - ax) + v * (cx - ax)) / 256),
			clamp_coord(ay + (u * (by - ay) + v * (cy - ay)) / 256),
			clamp_coord(az + (u * (bz - az) + v * (cz - az)) / 256
				+ $signed($urandom_range(3)) - 1));
	endfunction

	function automatic tri_query_t random_noise();
		tri_query_t t;
		t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom};
		return t;
	endfunction

	// Result checker: each accepted item is compared with the oldest expectation.
	always @(posedge clk) begin
		weights_t exp_w;
		if (arst_n && out_valid && out_ready) begin
			if (expected_weights.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item at cycle %0d", cycle_count);
			end else begin
				exp_w = expected_weights.pop_front();
				if (weight_a !== exp_w.wa || weight_b !== exp_w.wb ||
						weight_c !== exp_w.wc || degenerate !== exp_w.degen ||
						saturated !== exp_w.sat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %0d %0d %0d d=%b s=%b, got %0d %0d %0d d=%b s=%b",
							$signed(exp_w.wa), $signed(exp_w.wb), $signed(exp_w.wc),
							exp_w.degen, exp_w.sat, weight_a, weight_b, weight_c,
							degenerate, saturated);
				end
			end
		end
	end

	// Receiver: a long hold-off when asked, otherwise random stalls.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !take_break();
			end
		end
	end

	localparam coord_t ONE = 24'sh010000;
	localparam coord_t CMAX = 24'sh7FFFFF;
	localparam coord_t CMIN = 24'sh800000;

	// Extremes of the fields and the named special cases at the reset threshold.
	task automatic test_directed();
		// Every point equal: the denominator is zero, so the triangle is degenerate.
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// Unit right triangle, point inside, then on each vertex (an exact weight of one).
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0,
			coord_t'(ONE / 4), coord_t'(ONE / 4), 0));
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, ONE, 0));
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, 0));
		// Points far outside push weights past the Q3.28 range in both directions.
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, CMAX, CMIN, CMAX));
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, CMIN, CMAX, CMIN));
		// Just past the positive edge: a weight of about eight.
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, coord_t'(8 * ONE), 0, 0));
		// Largest possible triangle built from the field extremes.
		send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX,
			0, 0, 0));
		send_query(make_query(CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN,
			CMAX, CMAX, CMAX));
		// Collinear vertices give a zero denominator.
		send_query(make_query(0, 0, 0, ONE, ONE, ONE,
			coord_t'(2 * ONE), coord_t'(2 * ONE), coord_t'(2 * ONE), ONE, 0, 0));
		// The smallest triangle: its denominator is one, below the reset threshold.
		send_query(make_query(5, 5, 5, 6, 5, 5, 5, 6, 5, 6, 6, 5));
		drain();
	endtask

	// Threshold of zero lets the smallest triangles through; the maximum marks every
	// triangle degenerate whose denominator fits in 63 bits.
	task automatic test_threshold_extremes();
		write_threshold('0);
		send_query(make_query(5, 5, 5, 6, 5, 5, 5, 6, 5, 6, 6, 5));
		send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0));
		send_query(make_query(0, 0, 0, 1, 0, 0, 0, 1, 0, CMAX, CMAX, 0));
		send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1));
		repeat (40) send_query(random_triangle());
		write_threshold({bc_pkg::THRESH_W{1'b1}});
		send_query(make_query(0, 0, 0, ONE, 0, 0, 0, ONE, 0,
			coord_t'(ONE / 4), coord_t'(ONE / 4), 0));
		send_query(make_query(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX,
			0, 0, 0));
		repeat (40) send_query(random_triangle());
	endtask

	// Mostly well-formed triangles across several thresholds, some of them random.
	task automatic test_random_triangles();
		logic [bc_pkg::THRESH_W-1:0] th;
		for (int phase = 0; phase < 4; phase++) begin
			th = bc_pkg::THRESH_W'({$urandom, $urandom});
			th = (phase == 0) ? bc_pkg::THRESH_RESET : th >> $urandom_range(62);
			write_threshold(th);
			steady = (phase == 2);
			repeat (300) send_query(random_triangle());
			steady = 1'b0;
		end
	endtask

	// Raw random fields: every bit of every input takes both values.
	task automatic test_random_noise();
		write_threshold(bc_pkg::THRESH_RESET);
		repeat (250) send_query(random_noise());
	endtask

	// The receiver stops for a long stretch while items keep coming, so the
	// pipeline fills and in_ready falls.
	task automatic test_backpressure();
		hold_left = 300;
		repeat (150) send_query(random_triangle());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		query = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		degen_thresh = bc_pkg::THRESH_RESET;
		mismatches = 0;
		steady = 1'b0;
		hold_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_threshold_extremes();
		test_random_triangles();
		test_random_noise();
		test_backpressure();
		drain();

		if (mismatches == 0 && expected_weights.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
